/* src/q2e_pkg.sv */
// Shared types, constants and helper functions of the quaternion to Euler angle block.
`timescale 1ns / 1ps
`default_nettype none
package q2e_pkg;

  // Number of CORDIC micro-rotations; more than 32 acts as 32.
  localparam int CORDIC_STEPS = 16;
  localparam int CORD_N       = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  // One square root bit per cell, radicand up to 2^60.
  localparam int SQRT_N       = 31;

  localparam int VW = 37;  // CORDIC vector width
  localparam int AW = 26;  // angle accumulator width, 2^-16 degree

  localparam logic signed [AW-1:0] DEG90     = AW'(90 * 65536);
  localparam logic signed [15:0]   ROLL_LIM  = 16'sd23040;
  localparam logic signed [15:0]   PITCH_LIM = 16'sd11520;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [AW-1:0] z;
    logic                 zero;
  } vec_t;

  typedef struct packed {
    logic signed [33:0] rn;
    logic signed [33:0] rd;
    logic signed [33:0] yn;
    logic signed [33:0] yd;
    logic signed [31:0] s;
    logic               clamped;
  } side_t;

  typedef struct packed {
    logic [61:0] n;
    logic [61:0] res;
    side_t       side;
  } sqrt_t;

  typedef struct packed {
    vec_t roll;
    vec_t pitch;
    vec_t yaw;
    logic clamped;
  } cord_t;

  // atan(2^-i) in 2^-16 degree, rounded to nearest.
  function automatic logic signed [AW-1:0] atan_at(input logic [4:0] i);
    logic signed [AW-1:0] v;
    case (i)
      5'd0:    v = AW'(2949120);
      5'd1:    v = AW'(1740967);
      5'd2:    v = AW'(919879);
      5'd3:    v = AW'(466945);
      5'd4:    v = AW'(234379);
      5'd5:    v = AW'(117304);
      5'd6:    v = AW'(58666);
      5'd7:    v = AW'(29335);
      5'd8:    v = AW'(14668);
      5'd9:    v = AW'(7334);
      5'd10:   v = AW'(3667);
      5'd11:   v = AW'(1833);
      5'd12:   v = AW'(917);
      5'd13:   v = AW'(458);
      5'd14:   v = AW'(229);
      5'd15:   v = AW'(115);
      5'd16:   v = AW'(57);
      5'd17:   v = AW'(29);
      5'd18:   v = AW'(14);
      5'd19:   v = AW'(7);
      5'd20:   v = AW'(4);
      5'd21:   v = AW'(2);
      5'd22:   v = AW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Brings a vector into the right half plane and marks the all-zero case.
  function automatic vec_t prep(input logic signed [VW-1:0] y,
                                input logic signed [VW-1:0] x);
    vec_t v;
    v.zero = (x == '0) && (y == '0);
    v.x = x;
    v.y = y;
    v.z = '0;
    if (x[VW-1]) begin
      if (!y[VW-1]) begin
        v.x = y;
        v.y = -x;
        v.z = DEG90;
      end else begin
        v.x = -y;
        v.y = x;
        v.z = -DEG90;
      end
    end
    return v;
  endfunction

  // Rounds half up to 1/128 degree and saturates to +-lim.
  function automatic logic signed [15:0] to_out(input vec_t v,
                                                input logic signed [15:0] lim);
    logic signed [AW:0] r;
    logic signed [15:0] o;
    r = (AW'(v.z) + (AW+1)'(256)) >>> 9;
    if (v.zero) o = '0;
    else if (r > (AW+1)'(lim)) o = lim;
    else if (r < -(AW+1)'(lim)) o = -lim;
    else o = 16'(r);
    return o;
  endfunction

endpackage
`default_nettype wire

/* src/q2e_sqrt_cell.sv */
// One bit of the bitwise integer square root, with its own pipeline register.
`timescale 1ns / 1ps
`default_nettype none
module q2e_sqrt_cell (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire  [4:0]          bitpos,
  input  wire                 in_valid,
  output logic                in_ready,
  input  q2e_pkg::sqrt_t      in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output q2e_pkg::sqrt_t      out_data
);

  logic           vld_r, vld_nxt;
  q2e_pkg::sqrt_t dat_r, dat_nxt;
  logic [61:0]    one, trial;

  assign in_ready = !vld_r || out_ready;

  // Trial subtraction of res + 4^bitpos.
  always_comb begin
    one = 62'(1) << {bitpos, 1'b0};
    trial = in_data.res + one;
    dat_nxt = in_data;
    if (in_data.n >= trial) begin
      dat_nxt.n = in_data.n - trial;
      dat_nxt.res = (in_data.res >> 1) + one;
    end else begin
      dat_nxt.res = in_data.res >> 1;
    end
    vld_nxt = in_ready ? in_valid : vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      dat_r <= dat_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_data = dat_r;

endmodule
`default_nettype wire

/* src/q2e_cordic_cell.sv */
// One CORDIC vectoring micro-rotation for the roll, pitch and yaw lanes.
`timescale 1ns / 1ps
`default_nettype none
module q2e_cordic_cell (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire  [4:0]          step,
  input  wire                 in_valid,
  output logic                in_ready,
  input  q2e_pkg::cord_t      in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output q2e_pkg::cord_t      out_data
);

  logic           vld_r, vld_nxt;
  q2e_pkg::cord_t dat_r, dat_nxt;

  function automatic q2e_pkg::vec_t rot(input q2e_pkg::vec_t v, input logic [4:0] i);
    q2e_pkg::vec_t o;
    logic signed [q2e_pkg::VW-1:0] xs, ys;
    xs = v.x >>> i;
    ys = v.y >>> i;
    o = v;
    if (!v.y[q2e_pkg::VW-1]) begin
      o.x = v.x + ys;
      o.y = v.y - xs;
      o.z = v.z + q2e_pkg::atan_at(i);
    end else begin
      o.x = v.x - ys;
      o.y = v.y + xs;
      o.z = v.z - q2e_pkg::atan_at(i);
    end
    return o;
  endfunction

  assign in_ready = !vld_r || out_ready;

  // Rotate each lane toward the x axis.
  always_comb begin
    dat_nxt.roll = rot(in_data.roll, step);
    dat_nxt.pitch = rot(in_data.pitch, step);
    dat_nxt.yaw = rot(in_data.yaw, step);
    dat_nxt.clamped = in_data.clamped;
    vld_nxt = in_ready ? in_valid : vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      dat_r <= dat_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_data = dat_r;

endmodule
`default_nettype wire

/* src/quaternion_to_euler.sv */
// Top level: quaternion in, ZYX Euler angles out, through a chain of pipeline cells.
//
// Channel  Direction  Payload
// in_      slave      quat_x, quat_y, quat_z, quat_w (signed Q1.15 each)
// out_     master     roll_angle, pitch_angle, yaw_angle, pitch_clamped
//
// One request is taken every cycle while the output is not stalled; the path
// holds 3 arithmetic stages, 31 square root cells, one quadrant stage, one CORDIC
// cell per step, and the output register. Each cell stalls only when it is
// full and its successor is full, so bubbles close up under back pressure.
// Reset clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_euler (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // quat_x [15:0], quat_y [31:16], quat_z [47:32], quat_w [63:48]
  input  wire  [63:0] in_tdata,
  output logic        out_tvalid,
  input  wire         out_tready,
  // roll_angle [15:0], pitch_angle [30:16], yaw_angle [46:31], pitch_clamped [47]
  output logic [47:0] out_tdata
);

  localparam logic signed [33:0] ONE34 = 34'sd1 <<< 30;

  logic rdy_a, rdy_b, rdy_c, rdy_p, rdy_o;
  logic a_v_r, b_v_r, c_v_r, p_v_r, o_v_r;

  // Handshake and payload links of the square root and CORDIC chains.
  logic           sq_v   [0:q2e_pkg::SQRT_N];
  logic           sq_rdy [0:q2e_pkg::SQRT_N];
  q2e_pkg::sqrt_t sq_d   [0:q2e_pkg::SQRT_N];
  logic           cd_v   [0:q2e_pkg::CORD_N];
  logic           cd_rdy [0:q2e_pkg::CORD_N];
  q2e_pkg::cord_t cd_d   [0:q2e_pkg::CORD_N];

  // Stage A: the nine products.
  logic signed [15:0] qx, qy, qz, qw;
  logic signed [31:0] wx_r, yz_r, xx_r, yy_r, wz_r, xy_r, zz_r, wy_r, zx_r;

  assign qx = $signed(in_tdata[15:0]);
  assign qy = $signed(in_tdata[31:16]);
  assign qz = $signed(in_tdata[47:32]);
  assign qw = $signed(in_tdata[63:48]);
  assign rdy_a = !a_v_r || rdy_b;
  assign in_tready = rdy_a;

  always_ff @(posedge clk) begin
    if (in_tvalid && rdy_a) begin
      wx_r <= qw * qx;
      yz_r <= qy * qz;
      xx_r <= qx * qx;
      yy_r <= qy * qy;
      wz_r <= qw * qz;
      xy_r <= qx * qy;
      zz_r <= qz * qz;
      wy_r <= qw * qy;
      zx_r <= qz * qx;
    end
  end

  // Stage B: numerators, denominators and the clamped asin argument.
  logic signed [33:0] s_raw;
  q2e_pkg::side_t     b_nxt, b_r;

  assign rdy_b = !b_v_r || rdy_c;

  always_comb begin
    b_nxt.rn = (34'(wx_r) + 34'(yz_r)) <<< 1;
    b_nxt.rd = ONE34 - ((34'(xx_r) + 34'(yy_r)) <<< 1);
    b_nxt.yn = (34'(wz_r) + 34'(xy_r)) <<< 1;
    b_nxt.yd = ONE34 - ((34'(yy_r) + 34'(zz_r)) <<< 1);
    s_raw = (34'(wy_r) - 34'(zx_r)) <<< 1;
    b_nxt.clamped = (s_raw > ONE34) || (s_raw < -ONE34);
    if (s_raw > ONE34) b_nxt.s = 32'(ONE34);
    else if (s_raw < -ONE34) b_nxt.s = 32'(-ONE34);
    else b_nxt.s = 32'(s_raw);
  end

  always_ff @(posedge clk) begin
    if (a_v_r && rdy_b) begin
      b_r <= b_nxt;
    end
  end

  // Stage C: radicand 1 - s^2 in Q.60.
  logic signed [63:0] ss;
  q2e_pkg::sqrt_t     c_r;

  assign ss = b_r.s * b_r.s;
  assign rdy_c = !c_v_r || sq_rdy[0];

  always_ff @(posedge clk) begin
    if (b_v_r && rdy_c) begin
      c_r.n <= 62'((61'(1) << 60) - ss[60:0]);
      c_r.res <= '0;
      c_r.side <= b_r;
    end
  end

  // Square root chain.
  assign sq_v[0] = c_v_r;
  assign sq_d[0] = c_r;
  assign sq_rdy[q2e_pkg::SQRT_N] = rdy_p;

  for (genvar k = 0; k < q2e_pkg::SQRT_N; k++) begin : g_sqrt
    q2e_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .bitpos    (5'(q2e_pkg::SQRT_N - 1 - k)),
      .in_valid  (sq_v[k]),
      .in_ready  (sq_rdy[k]),
      .in_data   (sq_d[k]),
      .out_valid (sq_v[k+1]),
      .out_ready (sq_rdy[k+1]),
      .out_data  (sq_d[k+1])
    );
  end

  // Quadrant stage: move every vector into the right half plane.
  q2e_pkg::sqrt_t sq_o;
  q2e_pkg::cord_t p_r;

  assign sq_o = sq_d[q2e_pkg::SQRT_N];
  assign rdy_p = !p_v_r || cd_rdy[0];

  always_ff @(posedge clk) begin
    if (sq_v[q2e_pkg::SQRT_N] && rdy_p) begin
      p_r.roll <= q2e_pkg::prep(q2e_pkg::VW'(sq_o.side.rn), q2e_pkg::VW'(sq_o.side.rd));
      p_r.pitch <= q2e_pkg::prep(q2e_pkg::VW'(sq_o.side.s),
                                 $signed(q2e_pkg::VW'(sq_o.res[30:0])));
      p_r.yaw <= q2e_pkg::prep(q2e_pkg::VW'(sq_o.side.yn), q2e_pkg::VW'(sq_o.side.yd));
      p_r.clamped <= sq_o.side.clamped;
    end
  end

  // CORDIC chain.
  assign cd_v[0] = p_v_r;
  assign cd_d[0] = p_r;
  assign cd_rdy[q2e_pkg::CORD_N] = rdy_o;

  for (genvar k = 0; k < q2e_pkg::CORD_N; k++) begin : g_cordic
    q2e_cordic_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .step      (5'(k)),
      .in_valid  (cd_v[k]),
      .in_ready  (cd_rdy[k]),
      .in_data   (cd_d[k]),
      .out_valid (cd_v[k+1]),
      .out_ready (cd_rdy[k+1]),
      .out_data  (cd_d[k+1])
    );
  end

  // Output register: round, saturate and pack.
  q2e_pkg::cord_t     cd_o;
  logic signed [15:0] roll_o, pitch_o, yaw_o;
  logic [47:0]        out_r;

  assign cd_o = cd_d[q2e_pkg::CORD_N];
  assign roll_o = q2e_pkg::to_out(cd_o.roll, q2e_pkg::ROLL_LIM);
  assign pitch_o = q2e_pkg::to_out(cd_o.pitch, q2e_pkg::PITCH_LIM);
  assign yaw_o = q2e_pkg::to_out(cd_o.yaw, q2e_pkg::ROLL_LIM);
  assign rdy_o = !o_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (cd_v[q2e_pkg::CORD_N] && rdy_o) begin
      out_r <= {cd_o.clamped, yaw_o, pitch_o[14:0], roll_o};
    end
  end

  // Valid bits of the hand-built stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      p_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (rdy_a) a_v_r <= in_tvalid;
      if (rdy_b) b_v_r <= a_v_r;
      if (rdy_c) c_v_r <= b_v_r;
      if (rdy_p) p_v_r <= sq_v[q2e_pkg::SQRT_N];
      if (rdy_o) o_v_r <= cd_v[q2e_pkg::CORD_N];
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tdata = out_r;

endmodule
`default_nettype wire

/* src/q2e_checker.sv */
// Port-level checks of the quaternion to Euler angle block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module q2e_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire [63:0] in_tdata,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [47:0] out_tdata
);

  // A result waiting on back pressure keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Nothing comes out in the cycle after reset.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Handshake lines are known, and so is an accepted request.
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({in_tvalid, in_tready, out_tvalid}) &&
    (!(in_tvalid && in_tready) || !$isunknown(in_tdata)))
    else $error("unknown value on a handshake or accepted request");

  // Pitch stays within a quarter turn.
  a_pitch: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[30:16]) <= 15'sd11520) &&
                   ($signed(out_tdata[30:16]) >= -15'sd11520))
    else $error("pitch out of range");

  // Roll and yaw stay within a half turn.
  a_roll_yaw: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[15:0]) <= 16'sd23040) &&
                   ($signed(out_tdata[15:0]) >= -16'sd23040) &&
                   ($signed(out_tdata[46:31]) <= 16'sd23040) &&
                   ($signed(out_tdata[46:31]) >= -16'sd23040))
    else $error("roll or yaw out of range");

endmodule

bind quaternion_to_euler q2e_checker u_q2e_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
